### sv/cpu_alu_with_flags_top_assert.svh
// Assertion macros for the ALU top level.
// Used by cpu_alu_with_flags_top.sv; the enclosing module supplies clk and rst_n.
`ifndef CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAWF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cawf_pkg.sv
// Shared types and constants for the 8-bit ALU with flags.
// No dependencies; used by cawf_alu and cpu_alu_with_flags_top.
`timescale 1ns / 1ps

package cawf_pkg;

  // Action codes.
  localparam logic [4:0] ACT_ADD   = 5'd0;
  localparam logic [4:0] ACT_ADC   = 5'd1;
  localparam logic [4:0] ACT_SUB   = 5'd2;
  localparam logic [4:0] ACT_SBC   = 5'd3;
  localparam logic [4:0] ACT_AND   = 5'd4;
  localparam logic [4:0] ACT_XOR   = 5'd5;
  localparam logic [4:0] ACT_OR    = 5'd6;
  localparam logic [4:0] ACT_CP    = 5'd7;
  localparam logic [4:0] ACT_INC   = 5'd8;
  localparam logic [4:0] ACT_DEC   = 5'd9;
  localparam logic [4:0] ACT_DAA   = 5'd10;
  localparam logic [4:0] ACT_CPL   = 5'd11;
  localparam logic [4:0] ACT_CCF   = 5'd12;
  localparam logic [4:0] ACT_SCF   = 5'd13;
  localparam logic [4:0] ACT_RLC   = 5'd14;
  localparam logic [4:0] ACT_RRC   = 5'd15;
  localparam logic [4:0] ACT_RL    = 5'd16;
  localparam logic [4:0] ACT_RR    = 5'd17;
  localparam logic [4:0] ACT_SLA   = 5'd18;
  localparam logic [4:0] ACT_SRA   = 5'd19;
  localparam logic [4:0] ACT_SRL   = 5'd20;
  localparam logic [4:0] ACT_SWAP  = 5'd21;
  localparam logic [4:0] ACT_BIT   = 5'd22;
  localparam logic [4:0] ACT_RES   = 5'd23;
  localparam logic [4:0] ACT_SET   = 5'd24;
  localparam logic [4:0] ACT_ADD16 = 5'd25;
  localparam logic [4:0] ACT_SPE8  = 5'd26;

  // Flag bit positions inside the 4-bit flag word.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_LIMIT    = 8'h99;
  localparam logic [3:0] NIBBLE_LIMIT = 4'h9;

  // One input item.
  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
    logic        short_rotate;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        writes_result;
  } out_item_t;

endpackage

### sv/cpu_alu_with_flags_top.sv
// Top level of the 8-bit ALU with flags: input register, ALU, result register.
// Depends on cawf_pkg, cawf_alu and cpu_alu_with_flags_top_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one operation per item:
// action, two 16-bit operands, a bit index, the incoming Z/N/H/C flags and the
// short rotate select. The result channel (out_valid, out_ready, out_data)
// returns one item per input item, in order: result, new flags and write-enable.
// An accepted item is held in the input register, goes through the ALU and lands
// in the result register, which raises out_valid and holds the item until taken.
// The block takes one item every cycle while the receiver does not stall; that
// rate is set by the single pass through the ALU between the two registers.
// If the receiver stalls, the result register holds its item and the input
// register still takes one more item; in_ready drops only when both are full.
// Reset (rst_n low, synchronous) empties both registers; there is no other state.
//
`include "cpu_alu_with_flags_top_assert.svh"

module cpu_alu_with_flags_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cawf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cawf_pkg::out_item_t out_data
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  cawf_pkg::in_item_t  s1_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  cawf_pkg::out_item_t out_data_r;
  cawf_pkg::out_item_t alu_out;
  logic                s2_ready;

  // Handshake: each stage moves on when the one after it has room.
  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (s1_valid_r && s2_ready) out_data_r <= alu_out;
  end

  cawf_alu u_alu (
    .item_i (s1_data_r),
    .item_o (alu_out)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the pipeline control.
  `CAWF_ASSERT_SAME(a_stall_only_full, !in_ready, s1_valid_r && out_valid_r && !out_ready, "in_ready low while the pipeline has room")
  `CAWF_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, s1_valid_r, "accepted item missing from the input register")
  `CAWF_ASSERT_NEXT(a_advance_fills_out, s1_valid_r && s2_ready, out_valid_r, "item lost between input and result registers")
  `CAWF_ASSERT_SAME(a_nowrite_zero, out_valid_r && !out_data_r.writes_result, out_data_r.result == 16'd0, "flag-only result carries a nonzero value")

endmodule

### sv/cawf_alu.sv
// Combinational ALU datapath: one input item in, one result item out.
// Depends on cawf_pkg for the item types, action codes and constants.
`timescale 1ns / 1ps

module cawf_alu (
  input  cawf_pkg::in_item_t  item_i,
  output cawf_pkg::out_item_t item_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        zi;
  logic        ni;
  logic        hi;
  logic        ci;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [7:0]  bit_mask;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] spe8;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        wide;
  logic [3:0]  f;
  logic        w;

  assign a  = item_i.operand_a[7:0];
  assign b  = item_i.operand_b[7:0];
  assign zi = item_i.flags_in[cawf_pkg::FLAG_Z];
  assign ni = item_i.flags_in[cawf_pkg::FLAG_N];
  assign hi = item_i.flags_in[cawf_pkg::FLAG_H];
  assign ci = item_i.flags_in[cawf_pkg::FLAG_C];

  // Shared adder and subtractor; carry in only for the with-carry forms.
  assign cin_add = (item_i.action == cawf_pkg::ACT_ADC) & ci;
  assign cin_sub = (item_i.action == cawf_pkg::ACT_SBC) & ci;
  assign add9 = {1'b0, a} + {1'b0, b} + {8'b0, cin_add};
  assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin_add};
  assign sub9 = {1'b0, a} - {1'b0, b} - {8'b0, cin_sub};
  assign subh = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin_sub};
  assign inc8 = a + 8'd1;
  assign dec8 = a - 8'd1;
  assign bit_mask = 8'b1 << item_i.bit_index;

  // Sixteen-bit add and stack pointer plus signed byte.
  assign sum17 = {1'b0, item_i.operand_a} + {1'b0, item_i.operand_b};
  assign sum13 = {1'b0, item_i.operand_a[11:0]} + {1'b0, item_i.operand_b[11:0]};
  assign spe8  = item_i.operand_a + {{8{b[7]}}, b};

  // Decimal adjust after an add or a subtract.
  always_comb begin
    daa_r = a;
    daa_c = ci;
    if (ni) begin
      if (ci) daa_r = daa_r - cawf_pkg::DAA_HI_ADJ;
      if (hi) daa_r = daa_r - cawf_pkg::DAA_LO_ADJ;
    end else begin
      if (ci || (a > cawf_pkg::DAA_LIMIT)) begin
        daa_r = daa_r + cawf_pkg::DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (hi || (a[3:0] > cawf_pkg::NIBBLE_LIMIT)) daa_r = daa_r + cawf_pkg::DAA_LO_ADJ;
    end
  end

  // Result and flag selection by action.
  always_comb begin
    r8   = 8'd0;
    r16  = 16'd0;
    wide = 1'b0;
    f    = item_i.flags_in;
    w    = 1'b1;
    case (item_i.action)
      cawf_pkg::ACT_ADD, cawf_pkg::ACT_ADC: begin
        r8 = add9[7:0];
        f  = {add9[7:0] == 8'd0, 1'b0, addh[4], add9[8]};
      end
      cawf_pkg::ACT_SUB, cawf_pkg::ACT_SBC: begin
        r8 = sub9[7:0];
        f  = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
      end
      cawf_pkg::ACT_CP: begin
        f = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
        w = 1'b0;
      end
      cawf_pkg::ACT_AND: begin
        r8 = a & b;
        f  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      cawf_pkg::ACT_XOR: begin
        r8 = a ^ b;
        f  = {(a ^ b) == 8'd0, 3'b000};
      end
      cawf_pkg::ACT_OR: begin
        r8 = a | b;
        f  = {(a | b) == 8'd0, 3'b000};
      end
      cawf_pkg::ACT_INC: begin
        r8 = inc8;
        f  = {inc8 == 8'd0, 1'b0, a[3:0] == 4'hF, ci};
      end
      cawf_pkg::ACT_DEC: begin
        r8 = dec8;
        f  = {dec8 == 8'd0, 1'b1, a[3:0] == 4'h0, ci};
      end
      cawf_pkg::ACT_DAA: begin
        r8 = daa_r;
        f  = {daa_r == 8'd0, ni, 1'b0, daa_c};
      end
      cawf_pkg::ACT_CPL: begin
        r8 = ~a;
        f  = {zi, 1'b1, 1'b1, ci};
      end
      cawf_pkg::ACT_CCF: begin
        r8 = a;
        f  = {zi, 1'b0, 1'b0, ~ci};
      end
      cawf_pkg::ACT_SCF: begin
        r8 = a;
        f  = {zi, 1'b0, 1'b0, 1'b1};
      end
      cawf_pkg::ACT_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = {~item_i.short_rotate & ({a[6:0], a[7]} == 8'd0), 2'b00, a[7]};
      end
      cawf_pkg::ACT_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = {~item_i.short_rotate & ({a[0], a[7:1]} == 8'd0), 2'b00, a[0]};
      end
      cawf_pkg::ACT_RL: begin
        r8 = {a[6:0], ci};
        f  = {~item_i.short_rotate & ({a[6:0], ci} == 8'd0), 2'b00, a[7]};
      end
      cawf_pkg::ACT_RR: begin
        r8 = {ci, a[7:1]};
        f  = {~item_i.short_rotate & ({ci, a[7:1]} == 8'd0), 2'b00, a[0]};
      end
      cawf_pkg::ACT_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = {a[6:0] == 7'd0, 2'b00, a[7]};
      end
      cawf_pkg::ACT_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      cawf_pkg::ACT_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      cawf_pkg::ACT_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = {a == 8'd0, 3'b000};
      end
      cawf_pkg::ACT_BIT: begin
        f = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, ci};
        w = 1'b0;
      end
      cawf_pkg::ACT_RES: begin
        r8 = a & ~bit_mask;
      end
      cawf_pkg::ACT_SET: begin
        r8 = a | bit_mask;
      end
      cawf_pkg::ACT_ADD16: begin
        wide = 1'b1;
        r16  = sum17[15:0];
        f    = {zi, 1'b0, sum13[12], sum17[16]};
      end
      cawf_pkg::ACT_SPE8: begin
        // Flags come from the unsigned low-byte add, whatever the offset's sign.
        wide = 1'b1;
        r16  = spe8;
        f    = {1'b0, 1'b0, addh[4], add9[8]};
      end
      default: begin
        w = 1'b0;
      end
    endcase
  end

  assign item_o.result        = wide ? r16 : {8'd0, r8};
  assign item_o.flags_out     = f;
  assign item_o.writes_result = w;

endmodule
